@@ src/assert_macros.svh @@
// Assertion macros used by the queue RTL (sorted_priority_queue).
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

@@ src/spq_pkg.sv @@
// Types and codes for the sorted priority queue.
// Used by spq_cell and sorted_priority_queue; depends on nothing.
package spq_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = 5;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic CFG_REG_CAPACITY = 1'b0;
  localparam logic [CNT_W-1:0] CAPACITY_RESET = 5'd16;

  typedef struct packed {
    logic [15:0]        id;
    logic [15:0]        size;
    logic [7:0]         user;
    logic signed [15:0] prio;
  } spq_entry_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } spq_ctrl_t;

  typedef struct packed {
    logic               cmd;
    logic [15:0]        job_id;
    logic [15:0]        job_size;
    logic [7:0]         job_user;
    logic signed [15:0] job_priority;
  } spq_in_t;

  typedef struct packed {
    logic [15:0]        out_id;
    logic [15:0]        out_size;
    logic [7:0]         out_user;
    logic signed [15:0] out_priority;
    logic [1:0]         status;
    logic [CNT_W-1:0]   held_count;
    logic               is_full;
    logic               is_empty;
  } spq_out_t;

endpackage

@@ src/spq_cell.sv @@
// One slot of the sorted queue: holds an entry and shifts or loads it.
// Depends on spq_pkg for the entry and control types.
module spq_cell (
  input  logic               clk,
  input  spq_pkg::spq_ctrl_t ctrl_i,
  input  spq_pkg::spq_entry_t new_i,
  input  spq_pkg::spq_entry_t left_i,
  input  spq_pkg::spq_entry_t right_i,
  input  logic               left_gt_i,
  input  logic               occ_i,
  output spq_pkg::spq_entry_t q_o,
  output logic               gt_o
);
  import spq_pkg::*;

  spq_entry_t ent_r;
  spq_entry_t ent_nxt;

  // Because the row is sorted, the cells that outrank the new entry form a prefix.
  assign gt_o = occ_i && (ent_r.prio > new_i.prio);
  assign q_o  = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (ctrl_i.ins) begin
      if (gt_o) begin
        ent_nxt = ent_r;
      end else if (left_gt_i) begin
        ent_nxt = new_i;
      end else begin
        ent_nxt = left_i;
      end
    end else if (ctrl_i.rem) begin
      ent_nxt = right_i;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

@@ src/sorted_priority_queue.sv @@
// Sorted priority queue: a row of DEPTH cells kept in descending priority, head in cell 0.
// Depends on spq_pkg, spq_cell and assert_macros.svh.
//
// Each beat is one insert or remove and yields exactly one result beat in the next cycle.
// All cells compare their priority with the new entry and shift in the same cycle, so
// the queue takes one command per clock; the only back pressure is the output register,
// which is refilled in the cycle it is taken. Capacity (register 0) is clamped to
// 1..DEPTH and should be written only while no result is pending.
`include "assert_macros.svh"

module sorted_priority_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  spq_pkg::spq_in_t  in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output spq_pkg::spq_out_t out_data,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import spq_pkg::*;

  localparam int DW    = $clog2(DEPTH + 1);
  localparam int CMP_W = (DW > CNT_W) ? DW : CNT_W;

  logic [CNT_W-1:0] cap_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [CNT_W-1:0] eff_cap;
  logic             out_valid_r;
  spq_out_t         out_r;
  spq_out_t         out_nxt;
  logic             in_acc;
  logic             full;
  spq_ctrl_t        ctrl;
  spq_entry_t       new_ent;
  spq_entry_t       cell_q [DEPTH];
  logic [DEPTH-1:0] gt;
  logic [DEPTH-1:0] occ;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_REG_CAPACITY) ? 32'(cap_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAPACITY_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == CFG_REG_CAPACITY)) begin
      cap_r <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CNT_W'(1);
    end else if (CMP_W'(cap_r) > CMP_W'(DEPTH)) begin
      eff_cap = CNT_W'(DEPTH);
    end else begin
      eff_cap = cap_r;
    end
  end

  assign full      = (count_r >= eff_cap);
  assign in_stall  = out_valid_r && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign ctrl.ins  = in_acc && (in_data.cmd == CMD_INSERT) && !full;
  assign ctrl.rem  = in_acc && (in_data.cmd == CMD_REMOVE) && (count_r != '0);

  assign new_ent.id   = in_data.job_id;
  assign new_ent.size = in_data.job_size;
  assign new_ent.user = in_data.job_user;
  assign new_ent.prio = in_data.job_priority;

  // Row of cells; cell i is occupied when i is below the held count.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_entry_t left_ent;
    spq_entry_t right_ent;
    logic       left_gt;

    assign occ[i] = (CMP_W'(count_r) > CMP_W'(i));

    if (i == 0) begin : g_head
      assign left_ent = new_ent;
      assign left_gt  = 1'b1;
    end else begin : g_body
      assign left_ent = cell_q[i-1];
      assign left_gt  = gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_ent = cell_q[i];
    end else begin : g_mid
      assign right_ent = cell_q[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .ctrl_i    (ctrl),
      .new_i     (new_ent),
      .left_i    (left_ent),
      .right_i   (right_ent),
      .left_gt_i (left_gt),
      .occ_i     (occ[i]),
      .q_o       (cell_q[i]),
      .gt_o      (gt[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (ctrl.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctrl.rem) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    out_nxt = '0;
    if (ctrl.rem) begin
      out_nxt.out_id       = cell_q[0].id;
      out_nxt.out_size     = cell_q[0].size;
      out_nxt.out_user     = cell_q[0].user;
      out_nxt.out_priority = cell_q[0].prio;
    end
    if (in_data.cmd == CMD_INSERT) begin
      out_nxt.status = full ? ST_FULL : ST_DONE;
    end else begin
      out_nxt.status = (count_r == '0) ? ST_EMPTY : ST_DONE;
    end
    out_nxt.held_count = count_nxt;
    out_nxt.is_full    = (count_nxt >= eff_cap);
    out_nxt.is_empty   = (count_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `ASSERT_CLK(a_count_bounded, (CMP_W'(count_r) <= CMP_W'(DEPTH)), "count exceeds depth")
  `ASSERT_CLK(a_insert_counts, (ctrl.ins |=> count_r == $past(count_r) + CNT_W'(1)), "insert lost")
  `ASSERT_CLK(a_reject_holds, (in_acc && !ctrl.ins && !ctrl.rem |=> $stable(count_r)), "count moved")
  `ASSERT_CLK(a_remove_head, (ctrl.rem |=> out_valid && out_r.out_priority == $past(cell_q[0].prio)), "bad head")

endmodule

@@ tb/sv/spq_result_checker.sv @@
// Result checker for the sorted priority queue: tracks the capacity register and the held
// entries, predicts one result per accepted command beat and compares every result beat.
// Depends on spq_pkg for the beat types and the command and status codes.
module spq_result_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  spq_pkg::spq_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  spq_pkg::spq_out_t out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output int                fail_count,
  output int                pending,
  output int                results_seen,
  output int                full_rejects,
  output int                empty_removes
);
  timeunit 1ns;
  timeprecision 1ps;
  import spq_pkg::*;

  localparam logic [2:0] CAP_ADDR = 3'(4 * int'(CFG_REG_CAPACITY));

  spq_entry_t       slots [DEPTH];
  int               held;
  logic [CNT_W-1:0] capacity;
  spq_out_t         expected_results [$];
  int               mismatch_total = 0;
  int               result_total = 0;
  int               full_total = 0;
  int               empty_total = 0;

  // Register values outside 1..DEPTH act as the nearest end of that range.
  function automatic int effective_capacity();
    if (capacity == 0) return 1;
    if (capacity > DEPTH) return DEPTH;
    return int'(capacity);
  endfunction

  function automatic spq_out_t predict_queue_op(spq_in_t beat);
    spq_out_t   res;
    spq_entry_t job;
    int         pos;
    int         cap;
    res = '0;
    res.status = ST_DONE;
    cap = effective_capacity();
    if (beat.cmd == CMD_INSERT) begin
      if (held >= cap) begin
        res.status = ST_FULL;
      end else begin
        job.id   = beat.job_id;
        job.size = beat.job_size;
        job.user = beat.job_user;
        job.prio = beat.job_priority;
        pos = 0;
        // The new job goes ahead of the first entry that does not outrank it.
        while (pos < held && slots[pos].prio > job.prio) pos++;
        for (int i = held; i > pos; i--) slots[i] = slots[i-1];
        slots[pos] = job;
        held++;
      end
    end else begin
      if (held == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.out_id       = slots[0].id;
        res.out_size     = slots[0].size;
        res.out_user     = slots[0].user;
        res.out_priority = slots[0].prio;
        for (int i = 0; i + 1 < held; i++) slots[i] = slots[i+1];
        held--;
      end
    end
    res.held_count = CNT_W'(held);
    res.is_full    = (held >= cap);
    res.is_empty   = (held == 0);
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_total++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic check_field(string field, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
                                result_total, field, got, want));
    end
  endtask

  always @(posedge clk) begin : watch
    spq_out_t want;
    if (!rst_n) begin
      held = 0;
      capacity = CAPACITY_RESET;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == CAP_ADDR) begin
        capacity = pwdata[CNT_W-1:0];
      end
      // Results are checked before this edge's command is added, since a result can
      // never belong to a command accepted at the same edge.
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no command outstanding",
                                    result_total));
        end else begin
          want = expected_results.pop_front();
          check_field("id", out_data.out_id, want.out_id);
          check_field("size", out_data.out_size, want.out_size);
          check_field("user", out_data.out_user, want.out_user);
          check_field("priority", out_data.out_priority, want.out_priority);
          check_field("status", out_data.status, want.status);
          check_field("held_count", out_data.held_count, want.held_count);
          check_field("is_full", out_data.is_full, want.is_full);
          check_field("is_empty", out_data.is_empty, want.is_empty);
        end
        result_total++;
      end
      if (in_valid && !in_stall) begin
        want = predict_queue_op(in_data);
        if (want.status == ST_FULL) full_total++;
        if (want.status == ST_EMPTY) empty_total++;
        expected_results.push_back(want);
      end
    end
    fail_count    <= mismatch_total;
    pending       <= expected_results.size();
    results_seen  <= result_total;
    full_rejects  <= full_total;
    empty_removes <= empty_total;
  end

endmodule

@@ tb/sv/tb_top.sv @@
// Top of the sorted priority queue testbench: clock, reset, command and result traffic,
// capacity writes over the register port, a watchdog and the final verdict.
// Depends on spq_pkg, sorted_priority_queue and spq_result_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import spq_pkg::*;

  localparam int IDLE_LIMIT = 1000;
  localparam int HOLD_CYCLES = 80;
  localparam logic [2:0] CAP_ADDR = 3'(4 * int'(CFG_REG_CAPACITY));

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  spq_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  spq_out_t    out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic rx_idle_on;
  logic hold_req;
  logic hold_active;
  bit   tx_idle_on = 1'b0;
  int   beats_sent = 0;
  int   cap_writes = 0;

  int fail_count;
  int pending;
  int results_seen;
  int full_rejects;
  int empty_removes;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  sorted_priority_queue dut (.*);

  spq_result_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .fail_count(fail_count), .pending(pending), .results_seen(results_seen),
    .full_rejects(full_rejects), .empty_removes(empty_removes)
  );

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  function automatic spq_in_t random_job(int insert_pct);
    spq_in_t b;
    int      r;
    b.cmd      = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
    b.job_id   = 16'($urandom());
    b.job_size = 16'($urandom());
    b.job_user = 8'($urandom());
    r = $urandom_range(0, 9);
    // A narrow band of priorities makes ties common.
    if (r < 4) begin
      b.job_priority = 16'($urandom());
    end else if (r < 8) begin
      b.job_priority = 16'($urandom_range(0, 6) - 3);
    end else if (r == 8) begin
      b.job_priority = 16'h7fff;
    end else begin
      b.job_priority = 16'h8000;
    end
    return b;
  endfunction

  // Called just after clk rises; returns as soon as the queue has taken the beat.
  task automatic send_beat(spq_in_t beat);
    int gap;
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  task automatic job(logic cmd, logic [15:0] id, logic [15:0] size, logic [7:0] user,
                     logic [15:0] prio);
    spq_in_t b;
    b.cmd          = cmd;
    b.job_id       = id;
    b.job_size     = size;
    b.job_user     = user;
    b.job_priority = prio;
    send_beat(b);
  endtask

  task automatic run_random(int n, int insert_pct);
    repeat (n) send_beat(random_job(insert_pct));
  endtask

  // Stops offering beats and waits until every outstanding result has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic reconfigure(logic [CNT_W-1:0] cap);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= {27'($urandom()), cap};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cap_writes++;
  endtask

  initial begin : stimulus
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_data    <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    rx_idle_on <= 1'b0;
    hold_req   <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Back to back at the reset capacity: empty remove, field extremes and a tie.
    job(CMD_REMOVE, 16'h1234, 16'h5678, 8'h9a, 16'h0005);
    job(CMD_INSERT, 16'hffff, 16'hffff, 8'hff, 16'h7fff);
    job(CMD_INSERT, 16'h0000, 16'h0000, 8'h00, 16'h8000);
    job(CMD_INSERT, 16'h0001, 16'h0064, 8'h01, 16'h0000);
    job(CMD_INSERT, 16'h0002, 16'h00c8, 8'h02, 16'h0000);
    job(CMD_INSERT, 16'h0003, 16'h012c, 8'h03, 16'hffff);
    repeat (6) job(CMD_REMOVE, 16'h0000, 16'h0000, 8'h00, 16'h0000);

    // Small capacity, then capacity lowered below the held count.
    reconfigure(5'd2);
    tx_idle_on = 1'b1;
    rx_idle_on <= 1'b1;
    job(CMD_INSERT, 16'h00a0, 16'h0010, 8'h10, 16'h000a);
    job(CMD_INSERT, 16'h00a1, 16'h0011, 8'h11, 16'hfff6);
    job(CMD_INSERT, 16'h00a2, 16'h0012, 8'h12, 16'h0000);
    reconfigure(5'd1);
    job(CMD_INSERT, 16'h00a3, 16'h0013, 8'h13, 16'h7fff);
    repeat (3) job(CMD_REMOVE, 16'hffff, 16'hffff, 8'hff, 16'hffff);

    // A zero capacity behaves as one.
    reconfigure(5'd0);
    job(CMD_INSERT, 16'h00b0, 16'h0020, 8'h20, 16'h0001);
    job(CMD_INSERT, 16'h00b1, 16'h0021, 8'h21, 16'h0002);
    job(CMD_REMOVE, 16'h0000, 16'h0000, 8'h00, 16'h0000);

    // Above the depth: fill up until inserts bounce, then drain to empty.
    reconfigure(5'd31);
    run_random(60, 75);
    run_random(45, 25);

    reconfigure(5'd1);
    run_random(25, 50);

    // Long receiver hold while the sender keeps pushing, so the input backs up.
    reconfigure(5'd5);
    tx_idle_on = 1'b0;
    hold_req <= 1'b1;
    do @(posedge clk); while (!hold_active);
    run_random(40, 60);
    tx_idle_on = 1'b1;

    reconfigure(5'd8);
    run_random(40, 65);
    drain();
    run_random(40, 40);

    reconfigure(5'd0);
    run_random(20, 50);

    reconfigure(5'd16);
    run_random(60, 65);
    // A stretch with no idling on either side.
    tx_idle_on = 1'b0;
    rx_idle_on <= 1'b0;
    run_random(35, 35);
    tx_idle_on = 1'b1;
    rx_idle_on <= 1'b1;

    reconfigure(5'd17);
    run_random(25, 60);

    reconfigure(5'($urandom_range(1, DEPTH)));
    run_random(45, 55);

    drain();
    repeat (4) @(posedge clk);
    $display("Run covered %0d command beats and %0d result beats over %0d capacity writes.",
             beats_sent, results_seen, cap_writes);
    $display("%0d inserts met a full queue and %0d removes met an empty one.",
             full_rejects, empty_removes);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : receiver
    int len;
    bit hold_done;
    hold_done = 1'b0;
    hold_active <= 1'b0;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        hold_active <= 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
        hold_done = 1'b1;
      end else if (!rx_idle_on) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        len = pick_gap();
        if (len == 0) begin
          out_stall <= 1'b0;
          @(posedge clk);
        end else begin
          out_stall <= 1'b1;
          repeat (len) @(posedge clk);
        end
      end
    end
  end

  // Ends the run when nothing moves on any port for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    do begin
      @(posedge clk);
      if (rst_n && !(in_valid && !in_stall) && !(out_valid && !out_stall) &&
          !(psel && penable)) begin
        idle_cycles++;
      end else begin
        idle_cycles = 0;
      end
    end while (idle_cycles < IDLE_LIMIT);
    $display("Timeout: no beat moved for %0d cycles, %0d results outstanding.",
             IDLE_LIMIT, pending);
    $display("Some tests failed");
    $finish;
  end

endmodule
